>>> design/ccp_pkg.sv
// Shared widths, register codes and payload types of the capsule closest point unit.
package ccp_pkg;

  localparam int COORD_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int RAD_BITS    = COORD_BITS - 1;
  localparam int CORE_BITS   = COORD_BITS + 2;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int LEN_BITS    = DIFF_BITS + 1;
  localparam int SQ_BITS     = 2 * LEN_BITS;
  localparam int PROD_BITS   = RAD_BITS + DIFF_BITS;
  localparam int QUO_BITS    = RAD_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RAD_BITS-1:0] RADIUS_RESET = RAD_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [RAD_BITS-1:0] HEIGHT_RESET = RAD_BITS'(2) << FRAC_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Z   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAP_RADIUS = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAP_HEIGHT = 3'd4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic signed [COORD_BITS-1:0] near_z;
    logic                         is_inside;
  } result_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic [RAD_BITS-1:0]          cap_radius;
    logic [RAD_BITS-1:0]          cap_height;
  } cfg_t;

  // classified query handed from front to back
  typedef struct packed {
    point_t                       pt;
    logic signed [CORE_BITS-1:0]  core_y;
    logic [2:0]                   neg;
    logic [2:0][DIFF_BITS-1:0]    mag;
    logic [SQ_BITS-1:0]           dist2;
    logic                         in_body;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

>>> design/ccp_front.sv
// Front end: clamps onto the core segment, forms offsets, squared distance and inside flag.
module ccp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  ccp_pkg::point_t  point,
  input  ccp_pkg::cfg_t    cfg,
  output logic             push,
  output ccp_pkg::item_t   item
);

  localparam int CB = ccp_pkg::CORE_BITS;
  localparam int DB = ccp_pkg::DIFF_BITS;

  logic signed [CB-1:0] hd, h, ylo, yhi, py, cyc;
  logic signed [CB-1:0] d0_x, d0_y, d0_z;
  logic [2*ccp_pkg::RAD_BITS-1:0] r2;

  logic                  s1_v;
  ccp_pkg::point_t       s1_pt;
  logic signed [CB-1:0]  s1_core_y;
  logic [2:0][CB-1:0]    s1_d;

  logic                  s2_v;
  ccp_pkg::point_t       s2_pt;
  logic signed [CB-1:0]  s2_core_y;
  logic [2:0]            s2_neg;
  logic [2:0][DB-1:0]    s2_mag;
  logic [2:0][2*DB-1:0]  s2_sq;

  logic [2:0]            neg_c;
  logic [2:0][DB-1:0]    mag_c;
  logic [ccp_pkg::SQ_BITS-1:0] sum_c;

  // half length of the core segment and its y bounds
  always_comb begin
    hd  = $signed({3'b000, cfg.cap_height}) - $signed({2'b00, cfg.cap_radius, 1'b0});
    h   = (hd > 0) ? (hd >>> 1) : '0;
    ylo = CB'(cfg.center_y) - h;
    yhi = CB'(cfg.center_y) + h;
    py  = CB'(point.point_y);
    if (py < ylo) begin
      cyc = ylo;
    end else if (py > yhi) begin
      cyc = yhi;
    end else begin
      cyc = py;
    end
    d0_x = CB'(point.point_x) - CB'(cfg.center_x);
    d0_y = py - cyc;
    d0_z = CB'(point.point_z) - CB'(cfg.center_z);
  end

  always_comb begin
    logic signed [CB-1:0] dv;
    for (int j = 0; j < 3; j++) begin
      dv = $signed(s1_d[j]);
      neg_c[j] = dv[CB-1];
      mag_c[j] = dv[CB-1] ? DB'(-dv) : DB'(dv);
    end
  end

  assign r2    = cfg.cap_radius * cfg.cap_radius;
  assign sum_c = ccp_pkg::SQ_BITS'(s2_sq[0]) + ccp_pkg::SQ_BITS'(s2_sq[1])
               + ccp_pkg::SQ_BITS'(s2_sq[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      push <= 1'b0;
    end else begin
      s1_v <= take;
      s2_v <= s1_v;
      push <= s2_v;
    end
    s1_pt     <= point;
    s1_core_y <= cyc;
    s1_d      <= {d0_z, d0_y, d0_x};
    s2_pt     <= s1_pt;
    s2_core_y <= s1_core_y;
    s2_neg    <= neg_c;
    s2_mag    <= mag_c;
    for (int j = 0; j < 3; j++) begin
      s2_sq[j] <= mag_c[j] * mag_c[j];
    end
    item.pt      <= s2_pt;
    item.core_y  <= s2_core_y;
    item.neg     <= s2_neg;
    item.mag     <= s2_mag;
    item.dist2   <= sum_c;
    item.in_body <= (sum_c <= ccp_pkg::SQ_BITS'(r2));
  end

endmodule

>>> design/ccp_queue.sv
// Short queue between front and back.
module ccp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ccp_pkg::item_t         wr_item,
  input  logic                   pop,
  output ccp_pkg::item_t         rd_item,
  output ccp_pkg::queue_status_t status
);

  localparam int PB = $clog2(ccp_pkg::QUEUE_DEPTH);
  localparam int CNB = $clog2(ccp_pkg::QUEUE_DEPTH + 1);

  ccp_pkg::item_t  slots [ccp_pkg::QUEUE_DEPTH];
  logic [PB-1:0]   wr_ptr, rd_ptr;
  logic [CNB-1:0]  count, count_next;

  assign status.empty = (count == '0);
  assign status.full  = (count == CNB'(ccp_pkg::QUEUE_DEPTH));
  assign rd_item      = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PB'(ccp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PB'(ccp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && status.full))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("queue underflow");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule

>>> design/ccp_back.sv
// Back end: pipelined square root, scale by radius, pipelined divide, offset and saturate.
module ccp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  ccp_pkg::item_t    item,
  input  ccp_pkg::cfg_t     cfg,
  output logic              done,
  output ccp_pkg::result_t  result
);

  localparam int LB = ccp_pkg::LEN_BITS;
  localparam int SB = ccp_pkg::SQ_BITS;
  localparam int QB = ccp_pkg::QUO_BITS;
  localparam int CB = ccp_pkg::CORE_BITS;
  localparam int KB = ccp_pkg::COORD_BITS;
  localparam int PRB = ccp_pkg::PROD_BITS;
  localparam int SQRT_STEPS = LB;
  localparam int DIV_STEPS = QB;

  typedef struct packed {
    logic [LB+1:0] rem;
    logic [LB-1:0] root;
    logic [SB-1:0] rad;
  } root_t;

  typedef struct packed {
    logic [LB:0]   rem;
    logic [QB-1:0] quo;
    logic [QB-1:0] low;
  } div_t;

  logic [SQRT_STEPS-1:0] sv;
  root_t                 sq_st   [SQRT_STEPS];
  root_t                 sq_next [SQRT_STEPS];
  ccp_pkg::item_t        sq_item [SQRT_STEPS];

  logic                  mv;
  ccp_pkg::item_t        m_item;
  logic [LB-1:0]         m_len;
  logic [2:0][PRB-1:0]   m_prod;

  logic [DIV_STEPS-1:0]  dv;
  div_t                  dv_st   [DIV_STEPS][3];
  div_t                  dv_next [DIV_STEPS][3];
  logic [LB-1:0]         dv_len  [DIV_STEPS];
  ccp_pkg::item_t        dv_item [DIV_STEPS];

  logic [2:0][KB-1:0]    near_c;

  // one root bit per stage
  always_comb begin
    root_t src;
    logic [LB+1:0] acc, trial;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        src.rem  = '0;
        src.root = '0;
        src.rad  = item.dist2;
      end else begin
        src = sq_st[k-1];
      end
      acc   = {src.rem[LB-1:0], src.rad[SB-1 -: 2]};
      trial = {src.root, 2'b01};
      sq_next[k].rad = src.rad << 2;
      if (acc >= trial) begin
        sq_next[k].rem  = acc - trial;
        sq_next[k].root = {src.root[LB-2:0], 1'b1};
      end else begin
        sq_next[k].rem  = acc;
        sq_next[k].root = {src.root[LB-2:0], 1'b0};
      end
    end
  end

  // one quotient bit per stage in each lane
  always_comb begin
    div_t src;
    logic [LB:0] acc, dl;
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (k == 0) begin
          src.rem = (LB+1)'(m_prod[j][PRB-1:QB]);
          src.quo = '0;
          src.low = m_prod[j][QB-1:0];
          dl      = {1'b0, m_len};
        end else begin
          src = dv_st[k-1][j];
          dl  = {1'b0, dv_len[k-1]};
        end
        acc = {src.rem[LB-1:0], src.low[QB-1]};
        dv_next[k][j].low = src.low << 1;
        if (acc >= dl) begin
          dv_next[k][j].rem = acc - dl;
          dv_next[k][j].quo = {src.quo[QB-2:0], 1'b1};
        end else begin
          dv_next[k][j].rem = acc;
          dv_next[k][j].quo = {src.quo[QB-2:0], 1'b0};
        end
      end
    end
  end

  // add the offset to the core point and saturate
  always_comb begin
    ccp_pkg::item_t       it;
    logic signed [CB:0]   core, off, sum;
    it = dv_item[DIV_STEPS-1];
    for (int j = 0; j < 3; j++) begin
      case (j)
        0:       core = (CB+1)'(cfg.center_x);
        1:       core = (CB+1)'(it.core_y);
        default: core = (CB+1)'(cfg.center_z);
      endcase
      off = $signed({{(CB+1-QB){1'b0}}, dv_st[DIV_STEPS-1][j].quo});
      sum = it.neg[j] ? core - off : core + off;
      if ((&sum[CB:KB-1]) || !(|sum[CB:KB-1])) begin
        near_c[j] = sum[KB-1:0];
      end else begin
        near_c[j] = {sum[CB], {(KB-1){~sum[CB]}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    ccp_pkg::item_t it;
    it = dv_item[DIV_STEPS-1];
    if (rst) begin
      sv   <= '0;
      mv   <= 1'b0;
      dv   <= '0;
      done <= 1'b0;
    end else begin
      sv   <= {sv[SQRT_STEPS-2:0], take};
      mv   <= sv[SQRT_STEPS-1];
      dv   <= {dv[DIV_STEPS-2:0], mv};
      done <= dv[DIV_STEPS-1];
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      sq_st[k] <= sq_next[k];
      sq_item[k] <= (k == 0) ? item : sq_item[(k == 0) ? 0 : k-1];
    end
    m_item <= sq_item[SQRT_STEPS-1];
    m_len  <= sq_st[SQRT_STEPS-1].root;
    for (int j = 0; j < 3; j++) begin
      m_prod[j] <= cfg.cap_radius * sq_item[SQRT_STEPS-1].mag[j];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int j = 0; j < 3; j++) begin
        dv_st[k][j] <= dv_next[k][j];
      end
      dv_len[k]  <= (k == 0) ? m_len : dv_len[(k == 0) ? 0 : k-1];
      dv_item[k] <= (k == 0) ? m_item : dv_item[(k == 0) ? 0 : k-1];
    end
    if (it.in_body) begin
      result.near_x <= it.pt.point_x;
      result.near_y <= it.pt.point_y;
      result.near_z <= it.pt.point_z;
    end else begin
      result.near_x <= near_c[0];
      result.near_y <= near_c[1];
      result.near_z <= near_c[2];
    end
    result.is_inside <= it.in_body;
  end

endmodule

>>> design/capsule_closest_point_unit.sv
// Top level of the capsule closest point unit: configuration registers, front, queue, back.
//
// Usage:
//   Query channel: drive point and raise start; the point is taken at a rising edge
//   where start is high and busy is low. busy stays low in normal streaming, so one
//   point can be taken every cycle.
//   Result channel: done is high for exactly one cycle with result valid; the receiver
//   must take it then. Results come out in query order, one per query.
//   Pipeline: 3 front stages, one queue slot, 34 square root stages (one root bit each),
//   one radius multiply, 31 divide stages (one quotient bit each), one output stage.
//   Throughput: one query per cycle unless busy, from the fully pipelined root and divide.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high; index 0..4
//   selects center_x, center_y, center_z, cap_radius, cap_height. Zero radius or height
//   writes and unknown indexes are dropped. Write only while no query is in flight.
//   Reset (rst, synchronous): clears the pipeline and queue and loads center 0,
//   radius 0.5 and height 2.0. No clearing pass is needed.
module capsule_closest_point_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  ccp_pkg::point_t                    point,
  output logic                               done,
  output ccp_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ccp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [ccp_pkg::COORD_BITS-1:0]     cfg_data
);

  localparam int RB = ccp_pkg::RAD_BITS;

  ccp_pkg::cfg_t          cfg;
  ccp_pkg::item_t         f_item, q_item;
  ccp_pkg::queue_status_t q_status;
  logic                   f_push, q_pop, take;
  logic                   cfg_wr;
  logic [RB-1:0]          cfg_mag;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_mag   = cfg_data[RB-1:0];
  assign busy      = q_status.full;
  assign take      = start && !busy;
  assign q_pop     = !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x   <= '0;
      cfg.center_y   <= '0;
      cfg.center_z   <= '0;
      cfg.cap_radius <= ccp_pkg::RADIUS_RESET;
      cfg.cap_height <= ccp_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        ccp_pkg::REG_CENTER_X: cfg.center_x <= cfg_data;
        ccp_pkg::REG_CENTER_Y: cfg.center_y <= cfg_data;
        ccp_pkg::REG_CENTER_Z: cfg.center_z <= cfg_data;
        ccp_pkg::REG_CAP_RADIUS: begin
          if (cfg_mag != '0) cfg.cap_radius <= cfg_mag;
        end
        ccp_pkg::REG_CAP_HEIGHT: begin
          if (cfg_mag != '0) cfg.cap_height <= cfg_mag;
        end
        default: ;
      endcase
    end
  end

  ccp_front u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .point (point),
    .cfg   (cfg),
    .push  (f_push),
    .item  (f_item)
  );

  ccp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (f_push),
    .wr_item (f_item),
    .pop     (q_pop),
    .rd_item (q_item),
    .status  (q_status)
  );

  ccp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .take   (q_pop),
    .item   (q_item),
    .cfg    (cfg),
    .done   (done),
    .result (result)
  );

endmodule

>>> dv/capsule_closest_point_unit_tb.sv
// Self-checking testbench for the capsule closest point unit: directed table, random queries, config sweeps.
`timescale 1ns / 1ps
module capsule_closest_point_unit_tb;

  localparam int LATENCY = 71;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [ccp_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  logic clk, rst, start, busy, done, cfg_valid, cfg_ready;
  ccp_pkg::point_t point;
  ccp_pkg::result_t result;
  logic [ccp_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [ccp_pkg::COORD_BITS-1:0] cfg_data;

  capsule_closest_point_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor copy of the capsule registers
  logic signed [63:0] cap_cx, cap_cy, cap_cz;
  logic [63:0] cap_r, cap_h;

  ccp_pkg::result_t expected_q[$];
  int mismatches, results_seen, idle_cycles, accepted, inside_hits;
  logic watchdog_fired;

  typedef struct {
    ccp_pkg::point_t pt;
    logic has_exp;
    ccp_pkg::result_t exp_res;
  } row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] clamp_coord(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic ccp_pkg::result_t nearest_on_capsule(ccp_pkg::point_t p);
    logic signed [127:0] px, py, pz, hh, cy, dx, dy, dz, sum, r2, len, off;
    logic [127:0] acc, cand;
    ccp_pkg::result_t res;
    px = 128'(signed'(p.point_x));
    py = 128'(signed'(p.point_y));
    pz = 128'(signed'(p.point_z));
    hh = 0;
    if (cap_h > 2 * cap_r) hh = 128'((cap_h - 2 * cap_r) / 2);
    cy = py;
    if (cy < cap_cy - hh) cy = cap_cy - hh;
    if (cy > cap_cy + hh) cy = cap_cy + hh;
    dx = px - cap_cx;
    dy = py - cy;
    dz = pz - cap_cz;
    sum = dx * dx + dy * dy + dz * dz;
    r2 = 128'(cap_r) * 128'(cap_r);
    if (sum <= r2) begin
      res.near_x = p.point_x;
      res.near_y = p.point_y;
      res.near_z = p.point_z;
      res.is_inside = 1'b1;
    end else begin
      acc = 0;
      for (int b = 62; b >= 0; b--) begin
        cand = acc | (128'd1 << b);
        if (cand * cand <= sum) acc = cand;
      end
      len = acc;
      // truncate each offset magnitude, then restore the sign
      off = (128'(cap_r) * (dx < 0 ? -dx : dx)) / len;
      res.near_x = clamp_coord(dx < 0 ? cap_cx - off : cap_cx + off);
      off = (128'(cap_r) * (dy < 0 ? -dy : dy)) / len;
      res.near_y = clamp_coord(dy < 0 ? cy - off : cy + off);
      off = (128'(cap_r) * (dz < 0 ? -dz : dz)) / len;
      res.near_z = clamp_coord(dz < 0 ? cap_cz - off : cap_cz + off);
      res.is_inside = 1'b0;
    end
    return res;
  endfunction

  task automatic write_reg(logic [ccp_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    logic [63:0] u;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    u = 64'(val[30:0]);
    case (idx)
      ccp_pkg::REG_CENTER_X: cap_cx = 64'(signed'(val));
      ccp_pkg::REG_CENTER_Y: cap_cy = 64'(signed'(val));
      ccp_pkg::REG_CENTER_Z: cap_cz = 64'(signed'(val));
      ccp_pkg::REG_CAP_RADIUS: if (u != 0) cap_r = u;
      ccp_pkg::REG_CAP_HEIGHT: if (u != 0) cap_h = u;
      default: ;
    endcase
  endtask

  task automatic send_point(ccp_pkg::point_t p, logic gaps);
    if (gaps && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    expected_q.push_back(nearest_on_capsule(p));
    start <= 1'b1;
    point <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    accepted++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
      default: return 32'($signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000);
    endcase
  endfunction

  // near-capsule points mostly, with full-range ones mixed in
  task automatic random_block(int count, logic gaps);
    ccp_pkg::point_t p;
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 5);
      p.point_x = rand_coord(mode > 2 ? 2 : mode);
      p.point_y = rand_coord(mode > 2 ? 2 : mode);
      p.point_z = rand_coord(mode > 2 ? 2 : mode);
      send_point(p, gaps);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: result with nothing pending: %p", result);
        end else begin
          automatic ccp_pkg::result_t want = expected_q.pop_front();
          if (result.is_inside) inside_hits++;
          if (result !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: mismatch exp x=%h y=%h z=%h in=%b act x=%h y=%h z=%h in=%b",
                want.near_x, want.near_y, want.near_z, want.is_inside,
                result.near_x, result.near_y, result.near_z, result.is_inside);
          end
        end
      end
      if (done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && idle_cycles >= WATCHDOG_LIMIT && !watchdog_fired) begin
      watchdog_fired = 1'b1;
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    rst = 1'b1;
    start = 1'b0;
    point = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    results_seen = 0;
    accepted = 0;
    inside_hits = 0;
    watchdog_fired = 1'b0;
    cap_cx = 0;
    cap_cy = 0;
    cap_cz = 0;
    cap_r = 64'd32768;
    cap_h = 64'd131072;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows against the reset capsule (radius 0.5, height 2.0)
    rw.has_exp = 1'b1;
    rw.pt = '{32'd0, 32'd0, 32'd0};
    rw.exp_res = '{32'd0, 32'd0, 32'd0, 1'b1};
    rows.push_back(rw);
    rw.pt = '{32'd0, 32'h00010000, 32'd0};
    rw.exp_res = '{32'd0, 32'h00010000, 32'd0, 1'b1};
    rows.push_back(rw);
    rw.pt = '{32'h00010000, 32'd0, 32'd0};
    rw.exp_res = '{32'h00008000, 32'd0, 32'd0, 1'b0};
    rows.push_back(rw);
    rw.pt = '{32'd0, 32'h00100000, 32'd0};
    rw.exp_res = '{32'd0, 32'h00010000, 32'd0, 1'b0};
    rows.push_back(rw);
    rw.pt = '{32'd0, 32'd0, 32'h00008000};
    rw.exp_res = '{32'd0, 32'd0, 32'h00008000, 1'b1};
    rows.push_back(rw);
    rw.has_exp = 1'b0;
    rw.pt = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    rows.push_back(rw);
    rw.pt = '{32'h80000000, 32'h80000000, 32'h80000000};
    rows.push_back(rw);
    rw.pt = '{32'h80000000, 32'h7fffffff, 32'hffffffff};
    rows.push_back(rw);
    rw.pt = '{32'hffffffff, 32'h00004000, 32'h00000001};
    rows.push_back(rw);
    rw.pt = '{32'h00005a82, 32'hfffe8000, 32'h00005a82};
    rows.push_back(rw);
    foreach (rows[i]) begin
      if (rows[i].has_exp && nearest_on_capsule(rows[i].pt) !== rows[i].exp_res) begin
        mismatches++;
        $display("ERROR: predictor disagrees with directed row %0d", i);
      end
      send_point(rows[i].pt, 1'b0);
    end
    drain();

    // ignored writes: zero radius, zero height, unknown index
    write_reg(ccp_pkg::REG_CAP_RADIUS, 32'd0);
    write_reg(ccp_pkg::REG_CAP_HEIGHT, 32'h80000000);
    write_reg(REG_UNUSED, 32'h12345678);
    random_block(20, 1'b1);
    drain();

    // sphere case, then extremes of every register
    write_reg(ccp_pkg::REG_CAP_RADIUS, 32'h00030000);
    write_reg(ccp_pkg::REG_CAP_HEIGHT, 32'h00010000);
    random_block(100, 1'b1);
    drain();
    write_reg(ccp_pkg::REG_CENTER_X, 32'h7fffffff);
    write_reg(ccp_pkg::REG_CENTER_Y, 32'h80000000);
    write_reg(ccp_pkg::REG_CENTER_Z, 32'h7fffffff);
    write_reg(ccp_pkg::REG_CAP_RADIUS, 32'h00000001);
    write_reg(ccp_pkg::REG_CAP_HEIGHT, 32'h7fffffff);
    random_block(120, 1'b1);
    drain();
    write_reg(ccp_pkg::REG_CENTER_X, 32'h80000000);
    write_reg(ccp_pkg::REG_CENTER_Y, 32'h7fffffff);
    write_reg(ccp_pkg::REG_CENTER_Z, 32'h80000000);
    write_reg(ccp_pkg::REG_CAP_RADIUS, 32'h7fffffff);
    write_reg(ccp_pkg::REG_CAP_HEIGHT, 32'h00000001);
    random_block(120, 1'b1);
    drain();

    // several random capsules of moderate size near the origin; last one back to back
    for (int k = 0; k < 6; k++) begin
      write_reg(ccp_pkg::REG_CENTER_X, rand_coord(2));
      write_reg(ccp_pkg::REG_CENTER_Y, rand_coord(2));
      write_reg(ccp_pkg::REG_CENTER_Z, rand_coord(2));
      write_reg(ccp_pkg::REG_CAP_RADIUS, $urandom_range(1, 32'h00040000));
      write_reg(ccp_pkg::REG_CAP_HEIGHT, $urandom_range(1, 32'h00100000));
      random_block(130, k < 5);
      drain();
    end

    $display("Covered %0d queries over reset, sphere, extreme and random capsules;",
      accepted);
    $display("%0d results checked, %0d inside hits, %0d mismatches.",
      results_seen, inside_hits, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ccp_pkg.sv
design/ccp_front.sv
design/ccp_queue.sv
design/ccp_back.sv
design/capsule_closest_point_unit.sv
dv/capsule_closest_point_unit_tb.sv
